// File: rtl/amn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable number test - shared definitions
// Widths, microcode word layout and datapath status bundle.
// ----------------------------------------------------------------------------
package amn_pkg;

  localparam int VALUE_WIDTH = 32;
  // Trial divisor width: holds the integer root plus one step past it.
  localparam int IDX_WIDTH   = VALUE_WIDTH / 2 + 1;
  localparam int SQ_WIDTH    = 2 * IDX_WIDTH;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int PC_WIDTH    = 4;
  localparam int S_TDATA_W   = (VALUE_WIDTH + 7) / 8 * 8;
  localparam int M_TDATA_W   = (2 * VALUE_WIDTH + 2 + 7) / 8 * 8;

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
  localparam logic [CNT_WIDTH-1:0]   DIV_STEPS = CNT_WIDTH'(VALUE_WIDTH);

  typedef logic [PC_WIDTH-1:0] pc_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INIT,
    ACT_ZERO,
    ACT_DIV,
    ACT_ADDI,
    ACT_ADDQ,
    ACT_NEXT,
    ACT_SAVE1,
    ACT_EMIT
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SMALL,
    COND_SQ_GT,
    COND_DIV_BUSY,
    COND_REM_NZ,
    COND_OVF,
    COND_PASS1,
    COND_NEED2,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic lt_two;     // operand below two
    logic sq_gt;      // trial divisor squared exceeds operand
    logic div_busy;
    logic rem_nz;
    logic ovf;
    logic pass1;      // second pass (on the first sum) is running
    logic need2;      // first sum calls for a second pass
    logic out_full;   // result register cannot take a new result this cycle
  } status_t;

endpackage

// File: rtl/amn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable number test - iterative divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amn_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [amn_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [amn_pkg::VALUE_WIDTH-1:0]  divisor,
  output logic                             busy,
  output logic [amn_pkg::VALUE_WIDTH-1:0]  quotient,
  output logic [amn_pkg::VALUE_WIDTH-1:0]  remainder
);

  logic [amn_pkg::CNT_WIDTH-1:0]   count;
  logic [amn_pkg::VALUE_WIDTH-1:0] rem;
  logic [amn_pkg::VALUE_WIDTH-1:0] quo;
  logic [amn_pkg::VALUE_WIDTH:0]   shifted;
  logic [amn_pkg::VALUE_WIDTH:0]   diff;
  logic                            ge;
  logic [amn_pkg::VALUE_WIDTH-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[amn_pkg::VALUE_WIDTH-1]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    rem_next = ge ? diff[amn_pkg::VALUE_WIDTH-1:0] : shifted[amn_pkg::VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= amn_pkg::DIV_STEPS;
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[amn_pkg::VALUE_WIDTH-2:0], ge};
    end
  end

  assign busy      = count != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/amn_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable number test - microcode sequencer
// Step counter, control store and conditional jump select.
// ----------------------------------------------------------------------------
module amn_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  amn_pkg::status_t status,
  output amn_pkg::uword_t  ctl
);

  // Step addresses
  localparam amn_pkg::pc_t S_IDLE   = 4'd0;
  localparam amn_pkg::pc_t S_INIT   = 4'd1;
  localparam amn_pkg::pc_t S_TEST   = 4'd2;
  localparam amn_pkg::pc_t S_DIV    = 4'd3;
  localparam amn_pkg::pc_t S_WAIT   = 4'd4;
  localparam amn_pkg::pc_t S_CHECK  = 4'd5;
  localparam amn_pkg::pc_t S_ADDI   = 4'd6;
  localparam amn_pkg::pc_t S_ADDQ   = 4'd7;
  localparam amn_pkg::pc_t S_OVCHK  = 4'd8;
  localparam amn_pkg::pc_t S_NEXT   = 4'd9;
  localparam amn_pkg::pc_t S_ENDP   = 4'd10;
  localparam amn_pkg::pc_t S_SAVE1  = 4'd11;
  localparam amn_pkg::pc_t S_EMIT   = 4'd12;
  localparam amn_pkg::pc_t S_DONE   = 4'd13;
  localparam amn_pkg::pc_t S_ZERO   = 4'd14;

  amn_pkg::pc_t pc;
  amn_pkg::pc_t pc_next;
  logic         take;

  // Control store
  always_comb begin
    unique case (pc)
      S_IDLE:  ctl = '{amn_pkg::ACT_LOAD,  amn_pkg::COND_NO_INPUT, S_IDLE};
      S_INIT:  ctl = '{amn_pkg::ACT_INIT,  amn_pkg::COND_SMALL,    S_ZERO};
      S_TEST:  ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_SQ_GT,    S_ENDP};
      S_DIV:   ctl = '{amn_pkg::ACT_DIV,   amn_pkg::COND_NEVER,    S_IDLE};
      S_WAIT:  ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_DIV_BUSY, S_WAIT};
      S_CHECK: ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_REM_NZ,   S_NEXT};
      S_ADDI:  ctl = '{amn_pkg::ACT_ADDI,  amn_pkg::COND_NEVER,    S_IDLE};
      S_ADDQ:  ctl = '{amn_pkg::ACT_ADDQ,  amn_pkg::COND_NEVER,    S_IDLE};
      S_OVCHK: ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_OVF,      S_ENDP};
      S_NEXT:  ctl = '{amn_pkg::ACT_NEXT,  amn_pkg::COND_ALWAYS,   S_TEST};
      S_ENDP:  ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_PASS1,    S_EMIT};
      S_SAVE1: ctl = '{amn_pkg::ACT_SAVE1, amn_pkg::COND_NEED2,    S_INIT};
      S_EMIT:  ctl = '{amn_pkg::ACT_EMIT,  amn_pkg::COND_OUT_FULL, S_EMIT};
      S_DONE:  ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_ALWAYS,   S_IDLE};
      S_ZERO:  ctl = '{amn_pkg::ACT_ZERO,  amn_pkg::COND_ALWAYS,   S_ENDP};
      default: ctl = '{amn_pkg::ACT_NONE,  amn_pkg::COND_ALWAYS,   S_IDLE};
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      amn_pkg::COND_NEVER:    take = 1'b0;
      amn_pkg::COND_ALWAYS:   take = 1'b1;
      amn_pkg::COND_NO_INPUT: take = !status.in_valid;
      amn_pkg::COND_SMALL:    take = status.lt_two;
      amn_pkg::COND_SQ_GT:    take = status.sq_gt;
      amn_pkg::COND_DIV_BUSY: take = status.div_busy;
      amn_pkg::COND_REM_NZ:   take = status.rem_nz;
      amn_pkg::COND_OVF:      take = status.ovf;
      amn_pkg::COND_PASS1:    take = status.pass1;
      amn_pkg::COND_NEED2:    take = status.need2;
      amn_pkg::COND_OUT_FULL: take = status.out_full;
      default:                take = 1'b0;
    endcase
    pc_next = take ? ctl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/amn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable number test - datapath
// Operand, trial divisor and sum registers, divider and result register.
// ----------------------------------------------------------------------------
module amn_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  amn_pkg::uword_t                  ctl,
  output amn_pkg::status_t                 status,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [amn_pkg::VALUE_WIDTH-1:0]  in_candidate,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [amn_pkg::VALUE_WIDTH-1:0]  out_tested_value,
  output logic [amn_pkg::VALUE_WIDTH-1:0]  out_divisor_sum,
  output logic                             out_sum_overflow,
  output logic                             out_is_amicable
);

  localparam int VW = amn_pkg::VALUE_WIDTH;
  localparam int IW = amn_pkg::IDX_WIDTH;
  localparam int SW = amn_pkg::SQ_WIDTH;

  logic [VW-1:0] cand;
  logic [VW-1:0] opd;
  logic [IW-1:0] idx;
  logic [VW-1:0] sum;
  logic          ovf;
  logic          pass;
  logic [VW-1:0] s1;
  logic          ovf1;

  logic [SW-1:0] sq;
  logic [VW-1:0] idx_ext;
  logic          div_busy;
  logic [VW-1:0] quotient;
  logic [VW-1:0] remainder;
  logic [VW:0]   add_i;
  logic [VW:0]   add_q;
  logic          q_ne_i;
  logic          need2;
  logic          out_full;
  logic          emit;

  // Saturating add: carry flags overflow and pins the value at maximum.
  function automatic logic [VW:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[VW]) begin
      s = {1'b1, amn_pkg::VALUE_MAX};
    end
    return s;
  endfunction

  amn_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.act == amn_pkg::ACT_DIV),
    .dividend  (opd),
    .divisor   (idx_ext),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    idx_ext  = {{(VW - IW){1'b0}}, idx};
    sq       = idx * idx;
    add_i    = sat_add(sum, idx_ext);
    add_q    = sat_add(sum, quotient);
    q_ne_i   = quotient != idx_ext;
    need2    = !ovf && (cand < sum);
    out_full = out_valid && !out_ready;
    emit     = (ctl.act == amn_pkg::ACT_EMIT) && !out_full;
    in_ready = ctl.act == amn_pkg::ACT_LOAD;

    status.in_valid = in_valid;
    status.lt_two   = opd < VW'(2);
    status.sq_gt    = sq > {{(SW - VW){1'b0}}, opd};
    status.div_busy = div_busy;
    status.rem_nz   = remainder != '0;
    status.ovf      = ovf;
    status.pass1    = pass;
    status.need2    = need2;
    status.out_full = out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      unique case (ctl.act) inside
        amn_pkg::ACT_LOAD: begin
          if (in_valid) begin
            pass <= 1'b0;
          end
        end
        amn_pkg::ACT_INIT, amn_pkg::ACT_ZERO: begin
          ovf <= 1'b0;
        end
        amn_pkg::ACT_ADDI: begin
          if (add_i[VW]) begin
            ovf <= 1'b1;
          end
        end
        amn_pkg::ACT_ADDQ: begin
          if (q_ne_i && add_q[VW]) begin
            ovf <= 1'b1;
          end
        end
        amn_pkg::ACT_SAVE1: begin
          if (need2) begin
            pass <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.act)
      amn_pkg::ACT_LOAD: begin
        if (in_valid) begin
          cand <= in_candidate;
          opd  <= in_candidate;
        end
      end
      amn_pkg::ACT_INIT: begin
        sum <= VW'(1);
        idx <= IW'(2);
      end
      amn_pkg::ACT_ZERO: begin
        sum <= '0;
      end
      amn_pkg::ACT_ADDI: begin
        sum <= add_i[VW-1:0];
      end
      amn_pkg::ACT_ADDQ: begin
        if (q_ne_i) begin
          sum <= add_q[VW-1:0];
        end
      end
      amn_pkg::ACT_NEXT: begin
        idx <= idx + 1'b1;
      end
      amn_pkg::ACT_SAVE1: begin
        s1   <= sum;
        ovf1 <= ovf;
        if (need2) begin
          opd <= sum;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tested_value <= cand;
      out_divisor_sum  <= s1;
      out_sum_overflow <= ovf1;
      out_is_amicable  <= pass && !ovf && (sum == cand);
    end
  end

endmodule

// File: rtl/amicable_number_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable number test - top level
// Tests each candidate for being the lower member of an amicable pair.
// ----------------------------------------------------------------------------
// Usage:
//   Send one 32-bit candidate per transfer on the s_ channel. The block
//   forms s(n), the sum of proper divisors, by trial division up to the
//   integer root, then s(s(n)) when n < s(n), and returns one result per
//   candidate on the m_ channel: echo, s(n) (saturated), overflow flag and
//   amicable flag.
//   Trial loop: for each trial divisor over 2..isqrt(n) the sequencer starts
//   the radix-2 divider, waits until it finishes and checks the remainder;
//   a divisor that divides adds itself and, if different, its cofactor to
//   the sum. The second pass repeats this loop over 2..isqrt(s(n)).
//   Throughput: one candidate at a time; s_tready rises only while the
//   sequencer waits at its idle step, which it reaches through its done
//   step once the result is loaded.
//   Reset: rst returns the sequencer to idle and empties the result register.
//   Stall: a result waits in the output register while m_tready is low; the
//   next candidate is accepted and worked on meanwhile, and the sequencer
//   holds at its emit step only if the register is still full then.
// ----------------------------------------------------------------------------
module amicable_number_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [amn_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] candidate
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [amn_pkg::M_TDATA_W-1:0]   m_tdata   // [31:0] tested_value,
                                                    // [63:32] divisor_sum,
                                                    // [64] sum_overflow,
                                                    // [65] is_amicable,
                                                    // [71:66] zero
);

  localparam int VW = amn_pkg::VALUE_WIDTH;

  amn_pkg::uword_t  ctl;
  amn_pkg::status_t status;

  logic [VW-1:0] tested_value;
  logic [VW-1:0] divisor_sum;
  logic          sum_overflow;
  logic          is_amicable;

  // Step counter and control store
  amn_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  // Registers, divider and result register driven by the control word
  amn_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .status           (status),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_candidate     (s_tdata[VW-1:0]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_tested_value (tested_value),
    .out_divisor_sum  (divisor_sum),
    .out_sum_overflow (sum_overflow),
    .out_is_amicable  (is_amicable)
  );

  // Pack result fields, lowest first, zero pad to whole bytes
  assign m_tdata = {{(amn_pkg::M_TDATA_W - 2 * VW - 2){1'b0}},
                    is_amicable, sum_overflow, divisor_sum, tested_value};

endmodule
